[design/spd_pkg.sv]
`default_nettype none
package spd_pkg;

  typedef enum logic [2:0] {
    OP_SCALE,
    OP_GRAD2,
    OP_GRAD3,
    OP_RAY2,
    OP_RAY3
  } op_e;

  localparam logic [2:0] MODE_SCALE = 3'd0;
  localparam logic [2:0] MODE_GRAD2 = 3'd1;
  localparam logic [2:0] MODE_GRAD3 = 3'd2;
  localparam logic [2:0] MODE_RAY2  = 3'd3;
  localparam logic [2:0] MODE_RAY3  = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_ZERO  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;
  localparam logic [1:0] ST_BAD   = 2'd3;

  localparam logic [2:0] REG_SCALE_X  = 3'd0;
  localparam logic [2:0] REG_SCALE_Y  = 3'd1;
  localparam logic [2:0] REG_SCALE_Z  = 3'd2;
  localparam logic [2:0] REG_DILATION = 3'd3;
  localparam logic [2:0] REG_MODE     = 3'd4;
  localparam logic [2:0] REG_CENTER_X = 3'd5;
  localparam logic [2:0] REG_CENTER_Y = 3'd6;
  localparam logic [2:0] REG_CENTER_Z = 3'd7;

  localparam logic signed [15:0] DIL_MAX = 16'sd20480;

  localparam int SQ_STEPS   = 32;
  localparam int DIV_STEPS  = 14;
  localparam int BACK_STEPS = SQ_STEPS + 1 + DIV_STEPS;
  localparam int MAG_W      = 45;

  // square root and divider pipeline word
  typedef struct packed {
    op_e                           op;
    logic [1:0]                    status;
    logic signed [24:0]            ox;
    logic signed [24:0]            oy;
    logic signed [24:0]            oz;
    logic [2:0]                    neg;
    logic [63:0]                   rem;
    logic [31:0]                   root;
    logic [2:0][MAG_W-1:0]         mag;
    logic [2:0][DIV_STEPS-1:0]     quo;
  } back_t;

endpackage
`default_nettype wire

[design/spd_in_if.sv]
`default_nettype none
interface spd_in_if;
  logic               valid;
  logic               ready;
  logic               req_type;
  logic [9:0]         px;
  logic [9:0]         py;
  logic [9:0]         pz;
  logic signed [15:0] grad_x;
  logic signed [15:0] grad_y;
  logic signed [15:0] grad_z;
  logic [22:0]        slice_cx;
  logic [22:0]        slice_cy;

  modport source (
    output valid, req_type, px, py, pz, grad_x, grad_y, grad_z, slice_cx, slice_cy,
    input  ready
  );
  modport sink (
    input  valid, req_type, px, py, pz, grad_x, grad_y, grad_z, slice_cx, slice_cy,
    output ready
  );
endinterface
`default_nettype wire

[design/spd_out_if.sv]
`default_nettype none
interface spd_out_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] out_x;
  logic signed [23:0] out_y;
  logic signed [23:0] out_z;
  logic [1:0]         status;

  modport source (output valid, out_x, out_y, out_z, status, input ready);
  modport sink (input valid, out_x, out_y, out_z, status, output ready);
endinterface
`default_nettype wire

[design/spd_ram.sv]
`default_nettype none
module spd_ram #(
  parameter int W     = 46,
  parameter int DEPTH = 256
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [W-1:0]                           wdata_i,
  input  wire logic                                   re_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [W-1:0]                                rdata_o
);
  logic [W-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end
endmodule
`default_nettype wire

[design/spd_step.sv]
`default_nettype none
module spd_step #(
  parameter int K = 0
) (
  input  spd_pkg::back_t d_i,
  output spd_pkg::back_t d_o
);
  localparam int SB = spd_pkg::SQ_STEPS - 1 - K;
  localparam int DB = spd_pkg::SQ_STEPS + spd_pkg::DIV_STEPS - K;

  if (K < spd_pkg::SQ_STEPS) begin : g_sqrt
    // one root bit: (root + 2^b)^2 - root^2 = root * 2^(b+1) + 2^(2b)
    logic [63:0] trial;
    assign trial = ({32'd0, d_i.root} << (SB + 1)) | (64'd1 << (2 * SB));
    always_comb begin
      d_o = d_i;
      if (d_i.rem >= trial) begin
        d_o.rem  = d_i.rem - trial;
        d_o.root = d_i.root | (32'd1 << SB);
      end
    end
  end else if (K == spd_pkg::SQ_STEPS) begin : g_prep
    // round to nearest: add half the divisor before the floor division
    always_comb begin
      d_o = d_i;
      for (int j = 0; j < 3; j++) begin
        d_o.mag[j] = d_i.mag[j] + spd_pkg::MAG_W'(d_i.root >> 1);
      end
    end
  end else begin : g_div
    logic [spd_pkg::MAG_W-1:0] dsh;
    assign dsh = spd_pkg::MAG_W'(d_i.root) << DB;
    always_comb begin
      d_o = d_i;
      for (int j = 0; j < 3; j++) begin
        if (d_i.mag[j] >= dsh) begin
          d_o.mag[j]     = d_i.mag[j] - dsh;
          d_o.quo[j][DB] = 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

[design/surface_point_dilation.sv]
// Surface point dilation. Each point request is scaled to millimetres (Q.8) by the per-axis
// voxel size and moved by the signed dilation along the gradient or along a ray from a
// slice centre or the global centre; requests with req_type 0 load the slice centre table
// and give no response. One request is taken every clock cycle while the pipeline is not
// held; a point's response passes the 32 one-bit stages of the square root and the 14
// one-bit stages of the three-lane divider. The whole pipeline holds while the response
// register is full and not taken, except that it may still advance into an empty last
// stage. The user must write configuration only while the block is idle; the block
// itself does not enforce this.
`default_nettype none
module surface_point_dilation #(
  parameter int MAX_SLICES = 256
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  spd_in_if.sink           req_i,
  spd_out_if.source        rsp_o,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [23:0] cfg_data_i
);
  localparam int AW   = (MAX_SLICES > 1) ? $clog2(MAX_SLICES) : 1;
  localparam int BACK = spd_pkg::BACK_STEPS;

  typedef struct packed {
    spd_pkg::op_e       op;
    logic [1:0]         status;
    logic [21:0]        sx;
    logic [21:0]        sy;
    logic [21:0]        sz;
    logic signed [15:0] gx;
    logic signed [15:0] gy;
    logic signed [15:0] gz;
    logic signed [15:0] dil;
  } s0_t;

  typedef struct packed {
    spd_pkg::op_e       op;
    logic [1:0]         status;
    logic [21:0]        sx;
    logic [21:0]        sy;
    logic [21:0]        sz;
    logic signed [15:0] dil;
    logic signed [24:0] rx;
    logic signed [24:0] ry;
    logic signed [24:0] rz;
    logic signed [31:0] gpx;
    logic signed [31:0] gpy;
    logic signed [31:0] gpz;
  } s1_t;

  typedef struct packed {
    spd_pkg::op_e       op;
    logic [1:0]         status;
    logic signed [24:0] ox;
    logic signed [24:0] oy;
    logic signed [24:0] oz;
    logic [49:0]        sqx;
    logic [49:0]        sqy;
    logic [49:0]        sqz;
    logic signed [40:0] nx;
    logic signed [40:0] ny;
    logic signed [40:0] nz;
  } s2_t;

  typedef struct packed {
    logic signed [23:0] x;
    logic signed [23:0] y;
    logic signed [23:0] z;
    logic [1:0]         status;
  } rsp_t;

  function automatic logic [23:0] sat24(input logic signed [24:0] v);
    logic [23:0] r;
    if (v > 25'sd8388607) begin
      r = 24'h7fffff;
    end else if (v < -25'sd8388608) begin
      r = 24'h800000;
    end else begin
      r = v[23:0];
    end
    return r;
  endfunction

  // configuration
  logic [11:0]        scale_x_q, scale_y_q, scale_z_q;
  logic signed [15:0] dilation_q;
  logic [2:0]         mode_q;
  logic signed [23:0] center_x_q, center_y_q, center_z_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_x_q  <= 12'd256;
      scale_y_q  <= 12'd256;
      scale_z_q  <= 12'd256;
      dilation_q <= '0;
      mode_q     <= spd_pkg::MODE_SCALE;
      center_x_q <= '0;
      center_y_q <= '0;
      center_z_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        spd_pkg::REG_SCALE_X:  scale_x_q  <= cfg_data_i[11:0];
        spd_pkg::REG_SCALE_Y:  scale_y_q  <= cfg_data_i[11:0];
        spd_pkg::REG_SCALE_Z:  scale_z_q  <= cfg_data_i[11:0];
        spd_pkg::REG_DILATION: dilation_q <= $signed(cfg_data_i[15:0]);
        spd_pkg::REG_MODE:     mode_q     <= cfg_data_i[2:0];
        spd_pkg::REG_CENTER_X: center_x_q <= $signed(cfg_data_i);
        spd_pkg::REG_CENTER_Y: center_y_q <= $signed(cfg_data_i);
        spd_pkg::REG_CENTER_Z: center_z_q <= $signed(cfg_data_i);
        default: ;
      endcase
    end
  end

  // pipeline control
  logic             s0_v_q, s1_v_q, s2_v_q, out_v_q;
  logic [BACK:0]    bk_v_q;
  logic             out_free, adv, accept;

  assign out_free    = !out_v_q || rsp_o.ready;
  assign adv         = out_free || !bk_v_q[BACK];
  assign req_i.ready = adv;
  assign accept      = req_i.valid && adv;

  // front end
  logic               in_range;
  logic signed [15:0] dil_c;
  spd_pkg::op_e       op_in;
  logic [1:0]         st_in;
  s0_t                s0_d, s0_q;
  logic [45:0]        tab_rdata;

  assign in_range = 32'(req_i.pz) < 32'(MAX_SLICES);

  always_comb begin
    if (dilation_q > spd_pkg::DIL_MAX) begin
      dil_c = spd_pkg::DIL_MAX;
    end else if (dilation_q < -spd_pkg::DIL_MAX) begin
      dil_c = -spd_pkg::DIL_MAX;
    end else begin
      dil_c = dilation_q;
    end
    case (mode_q)
      spd_pkg::MODE_GRAD2: op_in = spd_pkg::OP_GRAD2;
      spd_pkg::MODE_GRAD3: op_in = spd_pkg::OP_GRAD3;
      spd_pkg::MODE_RAY2:  op_in = spd_pkg::OP_RAY2;
      spd_pkg::MODE_RAY3:  op_in = spd_pkg::OP_RAY3;
      default:             op_in = spd_pkg::OP_SCALE;
    endcase
    st_in = spd_pkg::ST_OK;
    if (dil_c == 16'sd0) begin
      op_in = spd_pkg::OP_SCALE;
    end
    if (op_in == spd_pkg::OP_RAY2 && !in_range) begin
      op_in = spd_pkg::OP_SCALE;
      st_in = spd_pkg::ST_RANGE;
    end
    s0_d.op     = op_in;
    s0_d.status = st_in;
    s0_d.sx     = 22'(req_i.px) * 22'(scale_x_q);
    s0_d.sy     = 22'(req_i.py) * 22'(scale_y_q);
    s0_d.sz     = 22'(req_i.pz) * 22'(scale_z_q);
    s0_d.gx     = req_i.grad_x;
    s0_d.gy     = req_i.grad_y;
    s0_d.gz     = req_i.grad_z;
    s0_d.dil    = dil_c;
  end

  // table read lines up with stage 0
  spd_ram #(
    .W     (46),
    .DEPTH (MAX_SLICES)
  ) u_tab (
    .clk_i   (clk_i),
    .we_i    (accept && !req_i.req_type && in_range),
    .waddr_i (AW'(req_i.pz)),
    .wdata_i ({req_i.slice_cy, req_i.slice_cx}),
    .re_i    (adv),
    .raddr_i (AW'(req_i.pz)),
    .rdata_o (tab_rdata)
  );

  // stage 0 -> 1: ray vector and gradient products
  s1_t                s1_d, s1_q;
  logic signed [24:0] sx25, sy25, sz25;

  assign sx25 = $signed({3'b000, s0_q.sx});
  assign sy25 = $signed({3'b000, s0_q.sy});
  assign sz25 = $signed({3'b000, s0_q.sz});

  always_comb begin
    s1_d.op     = s0_q.op;
    s1_d.status = s0_q.status;
    s1_d.sx     = s0_q.sx;
    s1_d.sy     = s0_q.sy;
    s1_d.sz     = s0_q.sz;
    s1_d.dil    = s0_q.dil;
    if (s0_q.op == spd_pkg::OP_RAY2) begin
      s1_d.rx = sx25 - $signed({2'b00, tab_rdata[22:0]});
      s1_d.ry = sy25 - $signed({2'b00, tab_rdata[45:23]});
      s1_d.rz = '0;
    end else begin
      s1_d.rx = sx25 - $signed({center_x_q[23], center_x_q});
      s1_d.ry = sy25 - $signed({center_y_q[23], center_y_q});
      s1_d.rz = sz25 - $signed({center_z_q[23], center_z_q});
    end
    s1_d.gpx = $signed(s0_q.gx) * $signed(s0_q.dil);
    s1_d.gpy = $signed(s0_q.gy) * $signed(s0_q.dil);
    s1_d.gpz = $signed(s0_q.gz) * $signed(s0_q.dil);
  end

  // stage 1 -> 2: squares, numerators, gradient moves
  s2_t                s2_d, s2_q;
  logic signed [49:0] sqx_s, sqy_s, sqz_s;
  logic signed [31:0] grx, gry, grz;
  logic signed [24:0] tx25, ty25, tz25;
  logic               grad_xy, grad_z;

  assign sqx_s = $signed(s1_q.rx) * $signed(s1_q.rx);
  assign sqy_s = $signed(s1_q.ry) * $signed(s1_q.ry);
  assign sqz_s = $signed(s1_q.rz) * $signed(s1_q.rz);
  assign grx   = ($signed(s1_q.gpx) + 32'sd8192) >>> 14;
  assign gry   = ($signed(s1_q.gpy) + 32'sd8192) >>> 14;
  assign grz   = ($signed(s1_q.gpz) + 32'sd8192) >>> 14;
  assign tx25  = $signed({3'b000, s1_q.sx});
  assign ty25  = $signed({3'b000, s1_q.sy});
  assign tz25  = $signed({3'b000, s1_q.sz});
  assign grad_xy = s1_q.op == spd_pkg::OP_GRAD2 || s1_q.op == spd_pkg::OP_GRAD3;
  assign grad_z  = s1_q.op == spd_pkg::OP_GRAD3;

  always_comb begin
    s2_d.op     = s1_q.op;
    s2_d.status = s1_q.status;
    s2_d.ox     = grad_xy ? tx25 + $signed(grx[24:0]) : tx25;
    s2_d.oy     = grad_xy ? ty25 + $signed(gry[24:0]) : ty25;
    s2_d.oz     = grad_z ? tz25 + $signed(grz[24:0]) : tz25;
    s2_d.sqx    = sqx_s;
    s2_d.sqy    = sqy_s;
    s2_d.sqz    = sqz_s;
    s2_d.nx     = $signed(s1_q.rx) * $signed(s1_q.dil);
    s2_d.ny     = $signed(s1_q.ry) * $signed(s1_q.dil);
    s2_d.nz     = $signed(s1_q.rz) * $signed(s1_q.dil);
  end

  // stage 2 -> back end: squared length, signs and magnitudes of r * d * 32
  spd_pkg::back_t      bk_in;
  logic [50:0]         n2;
  logic [2:0][40:0]    nabs;
  logic                is_ray;

  assign n2     = {1'b0, s2_q.sqx} + {1'b0, s2_q.sqy} + {1'b0, s2_q.sqz};
  assign is_ray = s2_q.op == spd_pkg::OP_RAY2 || s2_q.op == spd_pkg::OP_RAY3;

  always_comb begin
    nabs[0] = s2_q.nx[40] ? 41'(-s2_q.nx) : s2_q.nx;
    nabs[1] = s2_q.ny[40] ? 41'(-s2_q.ny) : s2_q.ny;
    nabs[2] = s2_q.nz[40] ? 41'(-s2_q.nz) : s2_q.nz;
    bk_in.op     = s2_q.op;
    bk_in.status = s2_q.status;
    if (is_ray && n2 == 51'd0) begin
      bk_in.op     = spd_pkg::OP_SCALE;
      bk_in.status = spd_pkg::ST_ZERO;
    end
    bk_in.ox   = s2_q.ox;
    bk_in.oy   = s2_q.oy;
    bk_in.oz   = s2_q.oz;
    bk_in.neg  = {s2_q.nz[40], s2_q.ny[40], s2_q.nx[40]};
    bk_in.rem  = {n2[49:0], 14'd0};
    bk_in.root = '0;
    for (int j = 0; j < 3; j++) begin
      bk_in.mag[j] = {nabs[j][39:0], 5'd0};
    end
    bk_in.quo = '0;
  end

  // back end: square root, rounding offset, division
  spd_pkg::back_t bk_q  [BACK+1];
  spd_pkg::back_t bk_nx [BACK];

  for (genvar k = 0; k < BACK; k++) begin : g_back
    spd_step #(.K(k)) u_step (
      .d_i (bk_q[k]),
      .d_o (bk_nx[k])
    );
  end

  // final move and saturation
  spd_pkg::back_t     lst;
  logic signed [24:0] qs [3];
  logic               mv_xy, mv_z;
  rsp_t               out_d, out_q;

  assign lst   = bk_q[BACK];
  assign mv_xy = lst.op == spd_pkg::OP_RAY2 || lst.op == spd_pkg::OP_RAY3;
  assign mv_z  = lst.op == spd_pkg::OP_RAY3;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      qs[j] = $signed({11'd0, lst.quo[j]});
      if (lst.neg[j]) begin
        qs[j] = -qs[j];
      end
    end
    out_d.x      = sat24($signed(lst.ox) + (mv_xy ? qs[0] : 25'sd0));
    out_d.y      = sat24($signed(lst.oy) + (mv_xy ? qs[1] : 25'sd0));
    out_d.z      = sat24($signed(lst.oz) + (mv_z ? qs[2] : 25'sd0));
    out_d.status = lst.status;
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q  <= 1'b0;
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      bk_v_q  <= '0;
      out_v_q <= 1'b0;
    end else begin
      if (adv) begin
        s0_v_q <= req_i.valid && req_i.req_type;
        s1_v_q <= s0_v_q;
        s2_v_q <= s1_v_q;
        bk_v_q <= {bk_v_q[BACK-1:0], s2_v_q};
      end
      if (out_free) begin
        out_v_q <= bk_v_q[BACK];
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s0_q    <= s0_d;
      s1_q    <= s1_d;
      s2_q    <= s2_d;
      bk_q[0] <= bk_in;
      for (int k = 0; k < BACK; k++) begin
        bk_q[k+1] <= bk_nx[k];
      end
    end
    if (out_free) begin
      out_q <= out_d;
    end
  end

  assign rsp_o.valid  = out_v_q;
  assign rsp_o.out_x  = out_q.x;
  assign rsp_o.out_y  = out_q.y;
  assign rsp_o.out_z  = out_q.z;
  assign rsp_o.status = out_q.status;

endmodule
`default_nettype wire

[design/spd_chk.sv]
`default_nettype none
module spd_chk (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        valid_i,
  input wire logic        ready_i,
  input wire logic [23:0] x_i,
  input wire logic [23:0] y_i,
  input wire logic [23:0] z_i,
  input wire logic [1:0]  status_i
);
  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !ready_i |=> valid_i)
    else $error("response dropped while stalled");

  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !ready_i |=> $stable(x_i) && $stable(y_i) && $stable(z_i) && $stable(status_i))
    else $error("response changed while stalled");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i |-> status_i != spd_pkg::ST_BAD)
    else $error("unknown status code");

  a_reset_idle: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !valid_i)
    else $error("response right after reset");
endmodule

bind surface_point_dilation spd_chk u_spd_chk (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .valid_i  (rsp_o.valid),
  .ready_i  (rsp_o.ready),
  .x_i      (rsp_o.out_x),
  .y_i      (rsp_o.out_y),
  .z_i      (rsp_o.out_z),
  .status_i (rsp_o.status)
);
`default_nettype wire
